### rtl/sms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_pkg: shared types and constants of the stepper move sequencer
// Status and command codes, default widths and the command and response words.
// ----------------------------------------------------------------------------
package sms_pkg;

	localparam int STEP_BITS_DEF = 16;
	localparam int WAIT_BITS_DEF = 16;
	localparam logic [7:0] PULSE_HIGH_RST = 8'd10;

	typedef enum logic [2:0] {
		ST_UNKNOWN = 3'd0,
		ST_CW_MAX  = 3'd1,
		ST_CCW_MAX = 3'd2,
		ST_MOV_CW  = 3'd3,
		ST_MOV_CCW = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		MODE_TICK       = 3'd0,
		MODE_START      = 3'd1,
		MODE_STOP       = 3'd2,
		MODE_DISABLE    = 3'd3,
		MODE_SET_STATUS = 3'd4
	} mode_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic        clockwise;
		logic [2:0]  end_status;
		logic        keep_enabled;
		logic [15:0] step_count;
		logic [15:0] wait_ticks;
		logic [2:0]  new_status;
		logic        force_req;
	} cmd_word_t;

	typedef struct packed {
		logic       accepted;
		logic [2:0] status_now;
		logic       motor_enabled;
		logic       step_level;
		logic       dir_level;
		logic       is_moving;
	} rsp_word_t;

endpackage

### rtl/sms_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_if: valid/ready channels of the stepper move sequencer
// One channel for command words, one for response words.
// ----------------------------------------------------------------------------
interface sms_cmd_if import sms_pkg::*; ();
	logic      valid;
	logic      ready;
	cmd_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sms_rsp_if import sms_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/stepper_move_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_move_sequencer: step/direction driver for an end-to-end motor
// Keeps the motion status, enable and pending move; answers every command word.
// ----------------------------------------------------------------------------
// Usage:
//  cmd carries one word per tick (one microsecond) or command: start, stop,
//  disable or set status. rsp returns exactly one word per command word with
//  the accept flag, status, enable, step and direction levels.
//  cfg_we/cfg_wdata write the step pulse width in ticks (0 acts as 1); write
//  it only while no word is in flight.
//  Latency: the response is valid in the cycle after the command is taken.
//  Throughput: one word per cycle while the response is not stalled; the state
//  update is a single pass of compare and count logic between the state
//  registers and the response register.
//  A stalled response is held in the output register; cmd.ready stays high
//  as long as that register is empty or is being emptied in the same cycle.
//  Reset: status unknown, motor disabled, no steps pending, keep flag set,
//  pulse width 10 ticks, no response pending.
// ----------------------------------------------------------------------------
module stepper_move_sequencer import sms_pkg::*; #(
	parameter int STEP_BITS = STEP_BITS_DEF,
	parameter int WAIT_BITS = WAIT_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata,
	sms_cmd_if.sink      cmd,
	sms_rsp_if.source    rsp
);

	localparam int TMR_BITS = WAIT_BITS;

	logic [7:0]           pulse_high_q;
	status_t              status_q, status_d;
	status_t              target_q, target_d;
	logic                 en_q, en_d;
	logic                 keep_q, keep_d;
	logic [STEP_BITS-1:0] steps_q, steps_d;
	logic [WAIT_BITS-1:0] wait_q, wait_d;
	logic [TMR_BITS-1:0]  timer_q, timer_d;
	logic                 phase_q, phase_d;
	logic                 dir_q, dir_d;

	logic                 rsp_valid_q;
	rsp_word_t            rsp_data_q;

	logic                 take;
	logic                 acc;
	logic                 level;
	logic [TMR_BITS-1:0]  t_inc;
	logic [TMR_BITS-1:0]  high_ext;
	logic [STEP_BITS-1:0] steps_in;
	logic                 moving_q;
	logic                 can_cw;
	logic                 can_ccw;
	logic                 end_ok;
	logic                 new_ok;
	logic                 moving_d;

	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign take      = cmd.valid && cmd.ready;

	assign moving_q = (status_q == ST_MOV_CW) || (status_q == ST_MOV_CCW);
	assign can_cw   = (status_q == ST_UNKNOWN) || (status_q == ST_CCW_MAX);
	assign can_ccw  = (status_q == ST_UNKNOWN) || (status_q == ST_CW_MAX);
	assign t_inc    = timer_q + TMR_BITS'(1);
	assign high_ext = (pulse_high_q == 8'd0) ? TMR_BITS'(1) : TMR_BITS'(pulse_high_q);
	assign steps_in = STEP_BITS'(cmd.data.step_count);
	assign end_ok   = cmd.data.end_status <= ST_MOV_CCW;
	assign new_ok   = cmd.data.new_status <= ST_MOV_CCW;
	assign moving_d = (status_d == ST_MOV_CW) || (status_d == ST_MOV_CCW);

	always_comb begin
		status_d = status_q;
		target_d = target_q;
		en_d     = en_q;
		keep_d   = keep_q;
		steps_d  = steps_q;
		wait_d   = wait_q;
		timer_d  = timer_q;
		phase_d  = phase_q;
		dir_d    = dir_q;
		acc      = 1'b1;
		level    = 1'b0;
		case (cmd.data.mode)
			MODE_TICK: begin
				if (moving_q) begin
					dir_d = (status_q == ST_MOV_CW);
					if (steps_q != '0) begin
						if (!phase_q) begin
							level = 1'b1;
							if (t_inc >= high_ext) begin
								timer_d = '0;
								phase_d = 1'b1;
								// no low time: the step ends on its last high tick
								if (wait_q == '0) begin
									phase_d = 1'b0;
									steps_d = steps_q - STEP_BITS'(1);
								end
							end else begin
								timer_d = t_inc;
							end
						end else if (t_inc >= wait_q) begin
							timer_d = '0;
							phase_d = 1'b0;
							steps_d = steps_q - STEP_BITS'(1);
						end else begin
							timer_d = t_inc;
						end
					end
					// move done: take the end status, drop the enable unless kept
					if (steps_d == '0) begin
						status_d = target_q;
						if (!keep_q) begin
							target_d = ST_UNKNOWN;
							steps_d  = '0;
							timer_d  = '0;
							phase_d  = 1'b0;
							en_d     = 1'b0;
						end
					end
				end
			end
			MODE_START: begin
				if (steps_in == '0 || !end_ok) begin
					acc = 1'b0;
				end else if (cmd.data.end_status == ST_UNKNOWN ||
						(cmd.data.end_status == ST_CCW_MAX && status_q == ST_CW_MAX) ||
						(cmd.data.end_status == ST_CW_MAX && status_q == ST_CCW_MAX) ||
						steps_in == STEP_BITS'(1)) begin
					// target sticks even when the status check below fails
					target_d = status_t'(cmd.data.end_status);
					if (cmd.data.clockwise ? can_cw : can_ccw) begin
						status_d = cmd.data.clockwise ? ST_MOV_CW : ST_MOV_CCW;
						en_d     = 1'b1;
						steps_d  = steps_in;
						keep_d   = cmd.data.keep_enabled;
						wait_d   = WAIT_BITS'(cmd.data.wait_ticks);
						timer_d  = '0;
						phase_d  = 1'b0;
					end else begin
						acc = 1'b0;
					end
				end else begin
					acc = 1'b0;
				end
			end
			MODE_STOP, MODE_DISABLE: begin
				target_d = ST_UNKNOWN;
				steps_d  = '0;
				timer_d  = '0;
				phase_d  = 1'b0;
				if (cmd.data.mode == MODE_DISABLE) begin
					en_d = 1'b0;
				end
			end
			MODE_SET_STATUS: begin
				if (!new_ok) begin
					acc = 1'b0;
				end else if (cmd.data.force_req) begin
					status_d = status_t'(cmd.data.new_status);
				end else if ((cmd.data.new_status == ST_MOV_CW && can_cw) ||
						(cmd.data.new_status == ST_MOV_CCW && can_ccw)) begin
					status_d = status_t'(cmd.data.new_status);
				end else begin
					acc = 1'b0;
				end
			end
			default: begin
				acc = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_high_q <= PULSE_HIGH_RST;
		end else if (cfg_we) begin
			pulse_high_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= ST_UNKNOWN;
			target_q <= ST_UNKNOWN;
			en_q     <= 1'b0;
			keep_q   <= 1'b1;
			steps_q  <= '0;
			wait_q   <= '0;
			timer_q  <= '0;
			phase_q  <= 1'b0;
			dir_q    <= 1'b0;
		end else if (take) begin
			status_q <= status_d;
			target_q <= target_d;
			en_q     <= en_d;
			keep_q   <= keep_d;
			steps_q  <= steps_d;
			wait_q   <= wait_d;
			timer_q  <= timer_d;
			phase_q  <= phase_d;
			dir_q    <= dir_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.ready) begin
			rsp_valid_q <= cmd.valid;
		end
	end

	// hold the response word while the receiver stalls
	always_ff @(posedge clk) begin
		if (take) begin
			rsp_data_q.accepted      <= acc;
			rsp_data_q.status_now    <= status_d;
			rsp_data_q.motor_enabled <= en_d;
			rsp_data_q.step_level    <= level;
			rsp_data_q.dir_level     <= dir_d;
			rsp_data_q.is_moving     <= moving_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

`ifndef SYNTHESIS
	a_no_take_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |-> !cmd.ready)
		else $error("command taken while response word stalled");

	a_step_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		take && cmd.data.mode != MODE_TICK |=> rsp.valid && !rsp.data.step_level)
		else $error("step level high on a command word");

	a_low_phase_has_steps: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> steps_q != '0)
		else $error("low phase with no step pending");
`endif

endmodule
